@@ hw/rtl/pfsd_pkg.sv @@
// Shared types and constants for the position follower with stall detect.
// No dependencies.
`default_nettype none
package pfsd_pkg;
  localparam logic [6:0] DUTY_CAP = 7'd100;
  localparam logic [47:0] ENERGY_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [16:0] STALL_MAX = 17'h1FFFF;
  typedef enum logic [2:0] {
    REG_DRIVE_GAIN = 3'd0,
    REG_ERROR_WEIGHT = 3'd1,
    REG_VELOCITY_GAIN = 3'd2,
    REG_MISMATCH_LIMIT = 3'd3,
    REG_STILL_LIMIT = 3'd4,
    REG_STALL_LIMIT = 3'd5
  } reg_index_t;
endpackage
`default_nettype wire

@@ hw/rtl/position_follower_with_stall_detect_top.sv @@
// Position follower with stall detect: P-control duty, error statistics,
// windowed velocity and a stall fault. Uses pfsd_pkg.
// Sequence: input transaction, then the read state after a start in mid-window,
// calc, post, the 56-step restoring divide of the window change and done; while
// a fault is latched, calc goes straight to done. One item at a time; the next
// transaction is taken the cycle after the result is accepted.
// Reset clears run state and loads register defaults; history is unset.
`default_nettype none
module position_follower_with_stall_detect_top
  import pfsd_pkg::*;
#(
  parameter int WINDOW = 100
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: reference_count[31:0], measured_count[63:32]
  input  wire logic [63:0] s_tdata,
  // tuser: start_run
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: forward_duty[6:0], reverse_duty[13:7], peak_error[45:14],
  // square_error_sum[93:46], zero[95:94]
  output logic [95:0]      m_tdata,
  // tuser: stall_fault
  output logic             m_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam int QW = 56;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_CALC, S_DIV, S_POST, S_DONE} state_t;
  state_t state;

  logic [15:0] drive_gain, error_weight, stall_limit;
  logic [23:0] velocity_gain, mismatch_limit, still_limit;

  logic [31:0] history [WINDOW];
  logic [31:0] hist_rd;
  logic [AW-1:0] write_slot;
  logic [CW-1:0] samples_seen;
  logic [16:0] stall_ticks;
  logic fault_latched;
  logic signed [31:0] largest_error;
  logic [47:0] error_energy;

  logic signed [31:0] meas, err;
  logic [6:0] duty;
  logic full;
  logic [CW-1:0] divisor;
  logic neg;
  logic [QW-1:0] quo, rem_mag;
  logic [CW:0] rem;
  logic [5:0] bitn;
  logic [63:0] sq;
  logic signed [57:0] vel;
  logic [6:0] fwd, rev;

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) hist_rd <= history[write_slot];
    if (state == S_CALC && !fault_latched) history[write_slot] <= meas;
  end

  logic signed [32:0] diff33;
  logic signed [31:0] err_sat;
  always_comb begin
    diff33 = $signed({s_tdata[31], s_tdata[31:0]}) - $signed({s_tdata[63], s_tdata[63:32]});
    if (diff33 > 33'sd2147483647) err_sat = 32'h7FFF_FFFF;
    else if (diff33 < -33'sd2147483648) err_sat = 32'h8000_0000;
    else err_sat = diff33[31:0];
  end

  logic [31:0] mag;
  logic [47:0] pdut;
  logic [48:0] esum;
  logic signed [32:0] change;
  logic signed [57:0] cprod;
  logic [CW:0] rem_try;
  logic signed [49:0] ew;
  logic signed [58:0] mism;
  logic [58:0] mism_abs;
  logic [57:0] vel_abs;
  always_comb begin
    mag = err[31] ? 32'(-err) : err;
    pdut = 48'({16'd0, mag} * {32'd0, drive_gain}) >> 8;
    esum = {1'b0, error_energy} + {1'b0, sq[47:0]};
    change = full ? ($signed({meas[31], meas}) - $signed({hist_rd[31], hist_rd}))
                  : $signed({meas[31], meas});
    cprod = 58'(change) * $signed({34'd0, velocity_gain});
    rem_try = {rem[CW-1:0], rem_mag[QW-1]};
    ew = 50'(err) * $signed({34'd0, error_weight});
    mism = 59'(ew) - 59'(vel);
    mism_abs = mism[58] ? 59'(-mism) : mism;
    vel_abs = vel[57] ? 58'(-vel) : 58'(vel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      drive_gain <= 16'd2370;
      error_weight <= 16'd119;
      velocity_gain <= 24'd118519;
      mismatch_limit <= 24'd5120;
      still_limit <= 24'd256;
      stall_limit <= 16'd1000;
      write_slot <= '0;
      samples_seen <= '0;
      stall_ticks <= '0;
      fault_latched <= 1'b0;
      largest_error <= '0;
      error_energy <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DRIVE_GAIN: drive_gain <= cfg_data[15:0];
          REG_ERROR_WEIGHT: error_weight <= cfg_data[15:0];
          REG_VELOCITY_GAIN: velocity_gain <= cfg_data;
          REG_MISMATCH_LIMIT: mismatch_limit <= cfg_data;
          REG_STILL_LIMIT: still_limit <= cfg_data;
          REG_STALL_LIMIT: stall_limit <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          meas <= s_tdata[63:32];
          err <= err_sat;
          if (s_tuser) begin
            write_slot <= '0;
            samples_seen <= '0;
            stall_ticks <= '0;
            fault_latched <= 1'b0;
            largest_error <= '0;
            error_energy <= '0;
          end
          state <= (s_tuser && write_slot != '0) ? S_READ : S_CALC;
        end
        S_READ: state <= S_CALC;
        S_CALC: begin
          fwd <= '0;
          rev <= '0;
          if (fault_latched) state <= S_DONE;
          else begin
            sq <= {32'd0, mag} * {32'd0, mag};
            duty <= (pdut > 48'(DUTY_CAP)) ? DUTY_CAP : pdut[6:0];
            if (err > largest_error) largest_error <= err;
            full <= samples_seen == CW'(WINDOW);
            divisor <= (samples_seen == CW'(WINDOW)) ? CW'(WINDOW) :
                       (samples_seen == '0) ? CW'(1) : samples_seen;
            if (samples_seen != CW'(WINDOW)) samples_seen <= samples_seen + 1'b1;
            write_slot <= (write_slot == AW'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
            state <= S_POST;
            bitn <= 6'd0;
          end
        end
        S_POST: begin
          neg <= cprod[57];
          rem_mag <= cprod[57] ? 56'(-cprod) : cprod[55:0];
          rem <= '0;
          quo <= '0;
          bitn <= 6'(QW);
          error_energy <= (esum[48] || sq[63:48] != '0) ? ENERGY_MAX : esum[47:0];
          if (err > 0) fwd <= duty; else rev <= duty;
          state <= S_DIV;
        end
        S_DIV: begin
          if (bitn != 0) begin
            rem_mag <= rem_mag << 1;
            if (rem_try >= {1'b0, divisor}) begin
              rem <= rem_try - {1'b0, divisor};
              quo <= {quo[QW-2:0], 1'b1};
            end else begin
              rem <= rem_try;
              quo <= {quo[QW-2:0], 1'b0};
            end
            bitn <= bitn - 1'b1;
          end else begin
            vel <= neg ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
            state <= S_DONE;
            bitn <= 6'd1;
          end
        end
        S_DONE: begin
          if (bitn == 6'd1) begin
            bitn <= 6'd0;
            if (mism_abs > 59'(mismatch_limit) && vel_abs < 58'(still_limit)) begin
              if (stall_ticks != STALL_MAX) stall_ticks <= stall_ticks + 1'b1;
              if (stall_ticks + 18'd1 > 18'(stall_limit)) begin
                fault_latched <= 1'b1;
                fwd <= '0;
                rev <= '0;
              end
            end else stall_ticks <= '0;
          end else begin
            m_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {2'b00, error_energy, largest_error, rev, fwd};
  assign m_tuser = fault_latched;

  logic unused;
  assign unused = ^rem[CW];

  a_duty_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (fwd <= DUTY_CAP && rev <= DUTY_CAP)) else $error("duty over cap");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (fwd == '0 || rev == '0)) else $error("both duties driven");
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (fwd == '0 && rev == '0)) else $error("drive under fault");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
endmodule
`default_nettype wire
